### rtl/core/assert_macros.svh
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cmt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cmt assertion failed");

`endif

### rtl/core/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants of the counted-set mex tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cmt_pkg;

  // Default sizing of the stores
  localparam int unsigned DEF_VALUE_RANGE = 4096;
  localparam int unsigned DEF_BLOCK_SIZE  = 64;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned LIMIT_W = 13;

  // APB register port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_IDX_VALUE_LIMIT = 1'b0;  // paddr[2]
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic [VALUE_W-1:0] mex;
    logic               found;
    logic               error;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/cmt_in_if.sv
// ----------------------------------------------------------------------------
// cmt_in_if
// Operation channel: op code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_in_if import cmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/cmt_out_if.sv
// ----------------------------------------------------------------------------
// cmt_out_if
// Result channel: mex, found and error flags, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_out_if import cmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] mex;
  logic               found;
  logic               error;

  modport source (output valid, output mex, output found, output error, input ready);
  modport sink   (input valid, input mex, input found, input error, output ready);
endinterface

`default_nettype wire

### rtl/core/counted_set_mex_tracker_top.sv
// ----------------------------------------------------------------------------
// counted_set_mex_tracker_top
// Multiset of small values with smallest-absent-value (mex) queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transfer per operation: op (add, remove, query) and value.
//   out_o : exactly one result transfer per operation, in order:
//           mex/found for queries, error for a failed add or remove.
//   APB   : value_limit at address 0. Values at or above the limit
//           (clamped to VALUE_RANGE) are ignored and the mex is searched
//           below it. Write it only while no operation is in flight.
// Sequence (accept to result valid):
//   add/remove    : S_FIX, S_CNT, S_BLK when the block present count changes.
//   ignored / op 3: straight to S_DONE.
//   query         : S_BRD/S_BCHK per block visited, then S_VRD/S_VCHK per
//                   value scanned in the first non-full block.
//   Every step goes through the single read port of the count RAM or of
//   the block RAM, each with registered read data.
//   One operation is worked on at a time; in_i.ready is high only while
//   the sequencer is idle.
// Reset: a clearing pass writes zero to every counter, one entry per cycle;
//   in_i.ready stays low until it ends. APB writes are taken throughout.
// Stall: a finished result sits in the output register; the next operation
//   is still accepted and runs up to its own result, which then waits until
//   out_o.ready takes the held one.
// ----------------------------------------------------------------------------
`default_nettype none

module counted_set_mex_tracker_top import cmt_pkg::*; #(
  parameter int unsigned VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int unsigned BLOCK_SIZE  = DEF_BLOCK_SIZE,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cmt_in_if.sink                  in_i,
  cmt_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  `include "assert_macros.svh"

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned NUM_BLOCKS = (VALUE_RANGE + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned LAST_SIZE  = VALUE_RANGE - (NUM_BLOCKS - 1) * BLOCK_SIZE;
  localparam int unsigned VW = $clog2(VALUE_RANGE);                 // value index
  localparam int unsigned BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned OW = $clog2(BLOCK_SIZE);                  // offset in block
  localparam int unsigned CW = $clog2(BLOCK_SIZE + 1);              // present count
  localparam int unsigned LW = (VW + 1 > LIMIT_W) ? VW + 1 : LIMIT_W;
  // Block index by reciprocal multiply: estimate is exact or one low.
  localparam int unsigned DIV_SH  = VALUE_W;
  localparam int unsigned DIV_MUL = (1 << VALUE_W) / BLOCK_SIZE;
  localparam int unsigned PW      = 2 * VALUE_W;

  // One-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,  // take an operation
    S_FIX  = 9'b000000010,  // correct block index, count read in flight
    S_CNT  = 9'b000000100,  // counter read-modify-write
    S_BLK  = 9'b000001000,  // block present count update
    S_BRD  = 9'b000010000,  // block count read in flight
    S_BCHK = 9'b000100000,  // skip full block, enter it or finish
    S_VRD  = 9'b001000000,  // counter read in flight
    S_VCHK = 9'b010000000,  // test one counter for zero
    S_DONE = 9'b100000000   // hand result to the output register
  } state_e;

  state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic               clr_busy_q;
  logic [VW-1:0]      clr_idx_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [VW-1:0]      v_q, v_d;
  logic [BW-1:0]      blk_q, blk_d;
  logic [LW-1:0]      start_q, start_d;
  logic [OW-1:0]      off_q, off_d;
  logic [VALUE_W-1:0] est_q;
  logic               is_add_q;
  logic               blk_inc_q, blk_inc_d;
  res_t               res_q, res_d;
  logic               out_valid_q;
  res_t               out_q;

  // RAM ports
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_wdata, cnt_ram_wdata;
  logic                   cnt_we, cnt_ram_we;
  logic [VW-1:0]          cnt_ram_waddr;
  logic [CW-1:0]          blk_rd, blk_wdata, blk_ram_wdata;
  logic                   blk_we, blk_ram_we;
  logic [BW-1:0]          blk_ram_waddr;

  // --------------------------------------------------------------------------
  // Shared datapath terms
  // --------------------------------------------------------------------------
  logic          accept;
  logic          out_load;
  logic [LW-1:0] eff_lim;
  logic [CW-1:0] bsize;
  logic          last_blk;
  logic [LW-1:0] next_start;
  logic          in_range;
  logic [PW-1:0] est_prod, est_rem;
  logic [BW-1:0] blk_fix;
  logic          cfg_we;

  assign accept   = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign eff_lim  = (LW'(limit_q) > LW'(VALUE_RANGE)) ? LW'(VALUE_RANGE) : LW'(limit_q);
  assign in_range = LW'(in_i.value) < eff_lim;

  assign last_blk   = (blk_q == BW'(NUM_BLOCKS - 1));
  assign bsize      = last_blk ? CW'(LAST_SIZE) : CW'(BLOCK_SIZE);
  assign next_start = start_q + LW'(bsize);

  // Remainder check lifts the estimate when it came out one low
  assign est_prod = PW'(est_q) * PW'(BLOCK_SIZE);
  assign est_rem  = PW'(v_q) - est_prod;
  assign blk_fix  = BW'(est_q) + BW'(est_rem >= PW'(BLOCK_SIZE));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    blk_d     = blk_q;
    start_d   = start_q;
    off_d     = off_q;
    blk_inc_d = blk_inc_q;
    res_d     = res_q;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rd;
    blk_we    = 1'b0;
    blk_wdata = blk_rd;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          v_d   = VW'(in_i.value);
          case (in_i.op) inside
            OP_ADD, OP_REMOVE: begin
              state_d = in_range ? S_FIX : S_DONE;
            end
            OP_QUERY: begin
              blk_d   = '0;
              start_d = '0;
              state_d = S_BRD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FIX: begin
        blk_d   = blk_fix;
        state_d = S_CNT;
      end

      S_CNT: begin
        state_d = S_DONE;
        if (is_add_q) begin
          if (&cnt_rd) begin
            res_d.error = 1'b1;            // saturated
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd + COUNT_WIDTH'(1);
            blk_inc_d = 1'b1;
            if (cnt_rd == '0) begin
              state_d = S_BLK;
            end
          end
        end else begin
          if (cnt_rd == '0) begin
            res_d.error = 1'b1;            // remove of absent value
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd - COUNT_WIDTH'(1);
            blk_inc_d = 1'b0;
            if (cnt_rd == COUNT_WIDTH'(1)) begin
              state_d = S_BLK;
            end
          end
        end
      end

      S_BLK: begin
        if (blk_inc_q) begin
          blk_we    = 1'b1;
          blk_wdata = blk_rd + CW'(1);
        end else if (blk_rd != '0) begin
          blk_we    = 1'b1;
          blk_wdata = blk_rd - CW'(1);
        end
        state_d = S_DONE;
      end

      S_BRD: begin
        state_d = S_BCHK;
      end

      S_BCHK: begin
        if (start_q >= eff_lim) begin
          state_d = S_DONE;                // nothing absent below the limit
        end else if (blk_rd >= bsize) begin
          if (last_blk) begin
            state_d = S_DONE;
          end else begin
            blk_d   = blk_q + BW'(1);
            start_d = next_start;
            state_d = S_BRD;
          end
        end else begin
          v_d     = VW'(start_q);
          off_d   = '0;
          state_d = S_VRD;
        end
      end

      S_VRD: begin
        state_d = S_VCHK;
      end

      S_VCHK: begin
        if (cnt_rd == '0) begin
          res_d.found = 1'b1;
          res_d.mex   = VALUE_W'(v_q);
          state_d     = S_DONE;
        end else if ((CW'(off_q) == bsize - CW'(1)) ||
                     (LW'(v_q) + LW'(1) >= eff_lim)) begin
          if (last_blk) begin
            state_d = S_DONE;
          end else begin
            blk_d   = blk_q + BW'(1);
            start_d = next_start;
            state_d = S_BRD;
          end
        end else begin
          v_d     = v_q + VW'(1);
          off_d   = off_q + OW'(1);
          state_d = S_VRD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + VW'(1);
        if (clr_idx_q == VW'(VALUE_RANGE - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cfg_we) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    blk_q     <= blk_d;
    start_q   <= start_d;
    off_q     <= off_d;
    blk_inc_q <= blk_inc_d;
    res_q     <= res_d;
    if (accept) begin
      is_add_q <= (in_i.op == OP_ADD);
      est_q    <= VALUE_W'((PW'(in_i.value) * PW'(DIV_MUL)) >> DIV_SH);
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stores; the clearing pass owns the write ports after reset
  // --------------------------------------------------------------------------
  assign cnt_ram_we    = clr_busy_q || cnt_we;
  assign cnt_ram_waddr = clr_busy_q ? clr_idx_q : v_q;
  assign cnt_ram_wdata = clr_busy_q ? '0 : cnt_wdata;

  assign blk_ram_we    = clr_busy_q ? (clr_idx_q < VW'(NUM_BLOCKS)) : blk_we;
  assign blk_ram_waddr = clr_busy_q ? BW'(clr_idx_q) : blk_q;
  assign blk_ram_wdata = clr_busy_q ? '0 : blk_wdata;

  cmt_ram #(
    .DEPTH (VALUE_RANGE),
    .WIDTH (COUNT_WIDTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_ram_we),
    .waddr_i (cnt_ram_waddr),
    .wdata_i (cnt_ram_wdata),
    .raddr_i (v_q),
    .rdata_o (cnt_rd)
  );

  cmt_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (CW)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_ram_we),
    .waddr_i (blk_ram_waddr),
    .wdata_i (blk_ram_wdata),
    .raddr_i (blk_q),
    .rdata_o (blk_rd)
  );

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_i.ready  = (state_q == S_IDLE) && !clr_busy_q;
  assign out_o.valid = out_valid_q;
  assign out_o.mex   = out_q.mex;
  assign out_o.found = out_q.found;
  assign out_o.error = out_q.error;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_VALUE_LIMIT);
  assign prdata = (paddr[2] == REG_IDX_VALUE_LIMIT) ? PDATA_W'(limit_q) : '0;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CMT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, state_q != S_IDLE)
  `CMT_ASSERT_NOW(a_found_xor_error, clk_i, rst_ni, out_valid_q, !(out_q.found && out_q.error))
  `CMT_ASSERT_NOW(a_inc_not_full, clk_i, rst_ni, (state_q == S_BLK) && blk_inc_q, blk_rd < bsize)
  `CMT_ASSERT_NOW(a_mex_below_limit, clk_i, rst_ni, out_load && res_q.found,
                  LW'(res_q.mex) < eff_lim)

endmodule

`default_nettype wire

### rtl/core/cmt_ram.sv
// ----------------------------------------------------------------------------
// cmt_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_ram import cmt_pkg::*; #(
  parameter  int unsigned DEPTH  = DEF_VALUE_RANGE,
  parameter  int unsigned WIDTH  = DEF_COUNT_WIDTH,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
